@@ design/adc_dac_q15_fir_lowpass_core_defines.svh @@
// Assertion macros for the filter core.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef ADC_DAC_Q15_FIR_LOWPASS_CORE_DEFINES_SVH
`define ADC_DAC_Q15_FIR_LOWPASS_CORE_DEFINES_SVH

`define ADFIR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("filter check failed");

`define ADFIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("filter check failed");

`endif

@@ design/adfir_pkg.sv @@
package adfir_pkg;

  localparam int TAPS        = 30;
  localparam int SAMPLE_BITS = 12;

  localparam int CODE_W  = 12;
  localparam int TAP_W   = 5;
  localparam int COEF_W  = 16;
  localparam int SMP_W   = SAMPLE_BITS + 1;
  localparam int PROD_W  = SMP_W + COEF_W;
  localparam int ACC_W   = PROD_W + $clog2(TAPS);
  localparam int Q_SHIFT = 15;
  localparam int Y_W     = ACC_W - Q_SHIFT;
  localparam int D_W     = COEF_W + 2;

  localparam int Q_MAX       = 32767;
  localparam int Q_MIN       = -32768;
  localparam int CODE_OFFSET = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int CODE_MAX    = (1 << SAMPLE_BITS) - 1;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_LOAD   = 1'b1
  } req_t;

  typedef struct packed {
    logic              vld;
    logic              load;
    logic [TAP_W-1:0]  tap;
    logic [COEF_W-1:0] coef;
    logic [SMP_W-1:0]  smp;
    logic [ACC_W-1:0]  acc;
    logic [PROD_W-1:0] prod;
  } beat_t;

endpackage

@@ design/adc_dac_q15_fir_lowpass_core.sv @@
// Q15 low-pass FIR between a 12-bit ADC and a 12-bit DAC. A sample beat
// (req_type 0) removes the ADC offset of 2047, runs through a 30-tap filter
// with a wide accumulator, is shifted right by 15, saturated to 16 bits, has
// the offset restored and is clamped to the DAC range; it gives exactly one
// result beat, with clipped set when saturation or clamping changed it. A load
// beat (req_type 1) writes one coefficient and gives no result; indexes of 30
// and above are ignored. Coefficients and history reset to zero. The block
// takes one beat per cycle while in_stall is low. Every beat passes through
// a row of 30 cells, one per tap, then a summing stage and the output
// register. Loads and samples keep their order through the row, so a
// coefficient takes effect from the next sample on. When a result waits
// with out_stall high, the whole row holds and in_stall follows it.
`include "adc_dac_q15_fir_lowpass_core_defines.svh"

module adc_dac_q15_fir_lowpass_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [adfir_pkg::CODE_W-1:0] in_adc_code,
  input  logic [adfir_pkg::TAP_W-1:0]  in_tap_index,
  input  logic signed [adfir_pkg::COEF_W-1:0] in_coef_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [adfir_pkg::CODE_W-1:0] out_dac_code,
  output logic                         out_clipped
);

  logic                               pipe_en;
  adfir_pkg::beat_t                   chain [adfir_pkg::TAPS+1];
  logic signed [adfir_pkg::SMP_W-1:0] x_s;

  assign pipe_en  = !out_valid || !out_stall;
  assign in_stall = !pipe_en;

  always_comb begin
    x_s = $signed({1'b0, in_adc_code[adfir_pkg::SAMPLE_BITS-1:0]})
        - adfir_pkg::SMP_W'(adfir_pkg::CODE_OFFSET);
    chain[0].vld  = in_valid;
    chain[0].load = (in_req_type == adfir_pkg::REQ_LOAD);
    chain[0].tap  = in_tap_index;
    chain[0].coef = in_coef_value;
    chain[0].smp  = x_s;
    chain[0].acc  = '0;
    chain[0].prod = '0;
  end

  for (genvar i = 0; i < adfir_pkg::TAPS; i++) begin : g_cell
    adfir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .cell_idx (adfir_pkg::TAP_W'(i)),
      .beat_i   (chain[i]),
      .beat_o   (chain[i+1])
    );
  end

  adfir_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (pipe_en),
    .beat_i       (chain[adfir_pkg::TAPS]),
    .out_valid    (out_valid),
    .out_dac_code (out_dac_code),
    .out_clipped  (out_clipped)
  );

  `ADFIR_ASSERT_NOW(a_stall_from_output, in_stall, out_valid && out_stall)
  `ADFIR_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)
  `ADFIR_ASSERT_NOW(a_mid_range_unclipped,
    out_valid && (out_dac_code != '0)
      && (out_dac_code != adfir_pkg::CODE_W'(adfir_pkg::CODE_MAX)),
    !out_clipped)
  `ADFIR_ASSERT_NEXT(a_load_no_result_ahead,
    in_valid && !in_stall && (in_req_type == adfir_pkg::REQ_LOAD) && !chain[adfir_pkg::TAPS].vld
      && !out_valid, !chain[1].vld || chain[1].load)

endmodule

@@ design/adfir_cell.sv @@
module adfir_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [adfir_pkg::TAP_W-1:0] cell_idx,
  input  adfir_pkg::beat_t           beat_i,
  output adfir_pkg::beat_t           beat_o
);

  logic [adfir_pkg::COEF_W-1:0]        w_r, w_nxt;
  logic [adfir_pkg::SMP_W-1:0]         h_r, h_nxt;
  adfir_pkg::beat_t                    beat_r, beat_nxt;
  logic                                is_smp, hit;
  logic signed [adfir_pkg::SMP_W-1:0]  smp_s;
  logic signed [adfir_pkg::COEF_W-1:0] w_s;
  logic signed [adfir_pkg::PROD_W-1:0] prod_s;
  logic signed [adfir_pkg::PROD_W-1:0] prod_in_s;
  logic signed [adfir_pkg::ACC_W-1:0]  acc_in_s, acc_s;

  // A sample beat takes the value shifted out of the previous cell and hands
  // on the value this cell held; the running sum travels with the beat.
  always_comb begin
    is_smp    = beat_i.vld && !beat_i.load;
    hit       = beat_i.vld && beat_i.load && (beat_i.tap == cell_idx);
    w_nxt     = hit ? beat_i.coef : w_r;
    h_nxt     = is_smp ? beat_i.smp : h_r;
    smp_s     = $signed(beat_i.smp);
    w_s       = $signed(w_r);
    prod_s    = smp_s * w_s;
    prod_in_s = $signed(beat_i.prod);
    acc_in_s  = $signed(beat_i.acc);
    acc_s     = acc_in_s + prod_in_s;
    beat_nxt      = beat_i;
    beat_nxt.smp  = h_r;
    beat_nxt.acc  = acc_s;
    beat_nxt.prod = prod_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r        <= '0;
      h_r        <= '0;
      beat_r.vld <= 1'b0;
    end else if (en) begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;

endmodule

@@ design/adfir_out.sv @@
module adfir_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  adfir_pkg::beat_t            beat_i,
  output logic                        out_valid,
  output logic [adfir_pkg::CODE_W-1:0] out_dac_code,
  output logic                        out_clipped
);

  logic                                sum_vld_r, sum_vld_nxt;
  logic signed [adfir_pkg::ACC_W-1:0]  sum_r, sum_nxt;
  logic signed [adfir_pkg::PROD_W-1:0] prod_s;
  logic signed [adfir_pkg::Y_W-1:0]    y_s;
  logic signed [adfir_pkg::COEF_W-1:0] sat_s;
  logic signed [adfir_pkg::D_W-1:0]    d_s;
  logic                                clip_q, clip_d;
  logic                                out_valid_r;
  logic [adfir_pkg::CODE_W-1:0]        dac_r, dac_nxt;
  logic                                clip_r, clip_nxt;

  always_comb begin
    prod_s      = $signed(beat_i.prod);
    sum_nxt     = $signed(beat_i.acc) + prod_s;
    sum_vld_nxt = beat_i.vld && !beat_i.load;
  end

  // Floor shift, saturation to 16 bits, offset restore and DAC clamp.
  always_comb begin
    y_s    = sum_r[adfir_pkg::ACC_W-1:adfir_pkg::Q_SHIFT];
    clip_q = 1'b0;
    if (y_s > adfir_pkg::Q_MAX) begin
      sat_s  = adfir_pkg::COEF_W'(adfir_pkg::Q_MAX);
      clip_q = 1'b1;
    end else if (y_s < adfir_pkg::Q_MIN) begin
      sat_s  = adfir_pkg::COEF_W'(adfir_pkg::Q_MIN);
      clip_q = 1'b1;
    end else begin
      sat_s = y_s[adfir_pkg::COEF_W-1:0];
    end
    d_s    = adfir_pkg::D_W'(sat_s) + adfir_pkg::D_W'(adfir_pkg::CODE_OFFSET);
    clip_d = 1'b0;
    if (d_s > adfir_pkg::CODE_MAX) begin
      dac_nxt = adfir_pkg::CODE_W'(adfir_pkg::CODE_MAX);
      clip_d  = 1'b1;
    end else if (d_s < 0) begin
      dac_nxt = '0;
      clip_d  = 1'b1;
    end else begin
      dac_nxt = d_s[adfir_pkg::CODE_W-1:0];
    end
    clip_nxt = clip_q || clip_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sum_vld_r   <= sum_vld_nxt;
      out_valid_r <= sum_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      dac_r  <= dac_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dac_code = dac_r;
  assign out_clipped  = clip_r;

endmodule
